// ===== hdl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Assert that an antecedent implies a consequent in the same cycle.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Assert that an antecedent implies a consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hdl/v4m4_pkg.sv =====
// Package with binary32 helpers and constants for the vector transform.
package v4m4_pkg;

    localparam int unsigned FpW = 32;
    localparam int unsigned RegCount = 8;
    localparam int unsigned IdxW = 3;
    localparam int unsigned Lanes = 3;
    localparam logic [FpW-1:0] DefaultNan = 32'h7FC0_0000;
    localparam logic [FpW-1:0] OneBits = 32'h3F80_0000;

    // Unpacked binary32 operand.
    typedef struct packed {
        logic        sign;
        logic [7:0]  exp;
        logic [22:0] frac;
    } t_fp32;

    // Special-value flags of an operand.
    typedef struct packed {
        logic is_nan;
        logic is_inf;
        logic is_zero;
    } t_fp_class;

    function automatic t_fp_class fp_classify(input logic [FpW-1:0] a);
        t_fp_class c;
        c.is_nan  = (a[30:23] == 8'hFF) && (a[22:0] != 23'd0);
        c.is_inf  = (a[30:23] == 8'hFF) && (a[22:0] == 23'd0);
        c.is_zero = (a[30:0] == 31'd0);
        return c;
    endfunction

    // Round a normalized magnitude: sig has the leading one at bit 26
    // (24 bits + guard + round + sticky below), exponent biased, may be <1.
    // Returns the packed binary32 value with sign.
    function automatic logic [FpW-1:0] fp_round_pack(
        input logic              sign,
        input logic signed [10:0] exp_in,
        input logic [26:0]       sig_in
    );
        logic [26:0] sig;
        logic [9:0]  shamt;
        logic        sticky;
        logic [24:0] mant;
        logic        rnd;
        logic signed [10:0] e;
        logic [FpW-1:0] res;
        sig = sig_in;
        e = exp_in;
        shamt = 10'd0;
        sticky = 1'b0;
        // Denormalize below the smallest normal exponent.
        if (e < 11'sd1) begin
            shamt = 10'(11'sd1 - e);
            if (shamt > 10'd27) begin
                sticky = |sig;
                sig = 27'd0;
            end else begin
                sticky = |(sig & ((27'd1 << shamt) - 27'd1));
                sig = sig >> shamt;
            end
            sig[0] = sig[0] | sticky;
            e = 11'sd0;
        end
        rnd = sig[2] & (sig[1] | sig[0] | sig[3]);
        mant = {1'b0, sig[26:3]} + {24'd0, rnd};
        if (mant[24]) begin
            mant = mant >> 1;
            e = e + 11'sd1;
        end else if (e == 11'sd0 && mant[23]) begin
            e = 11'sd1;
        end
        if (e >= 11'sd255) begin
            res = {sign, 8'hFF, 23'd0};
        end else begin
            res = {sign, e[7:0], mant[22:0]};
        end
        return res;
    endfunction

endpackage

// ===== hdl/vec4_mat4_transform_fp32_core.sv =====
// Top level: streaming 4x4 matrix by vector transform in binary32.
//
// Usage:
//  - Input stream s_axis: tdata carries vec_x, vec_y, vec_z, vec_w.
//  - Output stream m_axis: tdata carries out_x, out_y, out_z.
//  - Matrix: eight 64-bit registers on the write port (index 0..7),
//    each holding two column-major elements.
//    Write only while no transfer is in flight.
//  - Three parallel lanes, one per output component, each a multiply stage
//    and three chained add stages; results merge into one output word.
//  - Throughput: one vector per cycle while the output is not stalled; the whole pipe advances together.
//  - When the receiver stalls with a result waiting, every stage holds and
//    tready drops in the same cycle; empty stages are not filled meanwhile.
//  - Reset clears all stage valid bits and loads the identity matrix.
module vec4_mat4_transform_fp32_core
    import v4m4_pkg::*;
(
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          s_axis_tvalid,
    output logic          s_axis_tready,
    // vec_x[31:0], vec_y[63:32], vec_z[95:64], vec_w[127:96]
    input  logic [127:0]  s_axis_tdata,
    output logic          m_axis_tvalid,
    input  logic          m_axis_tready,
    // out_x[31:0], out_y[63:32], out_z[95:64]
    output logic [95:0]   m_axis_tdata,
    input  logic          i_cfg_we,
    input  logic [IdxW-1:0] i_cfg_idx,
    input  logic [63:0]   i_cfg_data
);

    localparam int unsigned Depth = 4;

    logic [FpW-1:0] r_mat [16];
    logic [Depth-1:0] r_vld;
    logic           w_en;
    logic [FpW-1:0] w_res [Lanes];

    // Advance when the last stage is empty or being drained.
    assign w_en = !r_vld[Depth-1] || m_axis_tready;
    assign s_axis_tready = w_en;
    assign m_axis_tvalid = r_vld[Depth-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            for (int k = 0; k < 16; k++) begin
                r_mat[k] <= ((k % 5) == 0) ? OneBits : '0;
            end
        end else begin
            if (w_en) begin
                r_vld <= {r_vld[Depth-2:0], s_axis_tvalid};
            end
            if (i_cfg_we) begin
                r_mat[{i_cfg_idx, 1'b0}] <= i_cfg_data[31:0];
                r_mat[{i_cfg_idx, 1'b1}] <= i_cfg_data[63:32];
            end
        end
    end

    // One lane per output component.
    for (genvar l = 0; l < Lanes; l++) begin : g_lane
        v4m4_lane u_lane (
            .i_clk (i_clk),
            .i_en  (w_en),
            .i_vec (s_axis_tdata),
            .i_col ({r_mat[12+l], r_mat[8+l], r_mat[4+l], r_mat[l]}),
            .o_res (w_res[l])
        );
    end

    // Merge lane results.
    assign m_axis_tdata = {w_res[2], w_res[1], w_res[0]};

endmodule

// ===== hdl/v4m4_fmul.sv =====
// Registered binary32 multiplier with round-to-nearest-even.
module v4m4_fmul
    import v4m4_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [FpW-1:0] i_a,
    input  logic [FpW-1:0] i_b,
    output logic [FpW-1:0] o_p
);

    t_fp_class ca, cb;
    logic [23:0] ma, mb;
    logic [47:0] prod;
    logic [5:0]  lza, lzb;
    logic [23:0] na, nb;
    logic signed [10:0] ea, eb, ep;
    logic [26:0] sig;
    logic        sgn;
    logic [FpW-1:0] n_p, r_p;

    // Count the leading zeros of an operand mantissa.
    function automatic logic [5:0] lz24(input logic [23:0] m);
        logic [5:0] n;
        n = 6'd24;
        for (int k = 0; k < 24; k++) begin
            if (m[k]) n = 6'(23 - k);
        end
        return n;
    endfunction

    always_comb begin
        ca = fp_classify(i_a);
        cb = fp_classify(i_b);
        sgn = i_a[31] ^ i_b[31];
        ma = {(i_a[30:23] != 8'd0), i_a[22:0]};
        mb = {(i_b[30:23] != 8'd0), i_b[22:0]};
        lza = lz24(ma);
        lzb = lz24(mb);
        na = ma << lza;
        nb = mb << lzb;
        ea = 11'($signed({3'd0, (i_a[30:23] == 8'd0) ? 8'd1 : i_a[30:23]})) - 11'($signed({5'd0, lza}));
        eb = 11'($signed({3'd0, (i_b[30:23] == 8'd0) ? 8'd1 : i_b[30:23]})) - 11'($signed({5'd0, lzb}));
        prod = na * nb;
        // Leading one at bit 47 or 46.
        if (prod[47]) begin
            ep = ea + eb - 11'sd126;
            sig = {prod[47:22], |prod[21:0]};
        end else begin
            ep = ea + eb - 11'sd127;
            sig = {prod[46:21], |prod[20:0]};
        end
        priority if (ca.is_nan || cb.is_nan || (ca.is_inf && cb.is_zero)
                     || (cb.is_inf && ca.is_zero)) begin
            n_p = DefaultNan;
        end else if (ca.is_inf || cb.is_inf) begin
            n_p = {sgn, 8'hFF, 23'd0};
        end else if (ca.is_zero || cb.is_zero) begin
            n_p = {sgn, 31'd0};
        end else begin
            n_p = fp_round_pack(sgn, ep, sig);
        end
    end

    // Hold the product while stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p <= n_p;
        end
    end

    assign o_p = r_p;

endmodule

// ===== hdl/v4m4_fadd.sv =====
// Registered binary32 adder with round-to-nearest-even.
module v4m4_fadd
    import v4m4_pkg::*;
(
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [FpW-1:0] i_a,
    input  logic [FpW-1:0] i_b,
    output logic [FpW-1:0] o_s
);

    t_fp_class ca, cb;
    logic [FpW-1:0] big, lit;
    logic [7:0]  eb_, el_;
    logic [26:0] mb_, ml_, mls;
    logic [7:0]  d;
    logic [27:0] sum;
    logic [4:0]  lz;
    logic [27:0] nsum;
    logic signed [10:0] er;
    logic [FpW-1:0] n_s, r_s;

    always_comb begin
        ca = fp_classify(i_a);
        cb = fp_classify(i_b);
        // Order operands by magnitude.
        if (i_a[30:0] >= i_b[30:0]) begin
            big = i_a;
            lit = i_b;
        end else begin
            big = i_b;
            lit = i_a;
        end
        eb_ = (big[30:23] == 8'd0) ? 8'd1 : big[30:23];
        el_ = (lit[30:23] == 8'd0) ? 8'd1 : lit[30:23];
        mb_ = {(big[30:23] != 8'd0), big[22:0], 3'd0};
        ml_ = {(lit[30:23] != 8'd0), lit[22:0], 3'd0};
        d = eb_ - el_;
        if (d > 8'd26) begin
            mls = {26'd0, |ml_};
        end else begin
            mls = (ml_ >> d) | {26'd0, |(ml_ & ((27'd1 << d) - 27'd1))};
        end
        if (big[31] == lit[31]) begin
            sum = {1'b0, mb_} + {1'b0, mls};
        end else begin
            sum = {1'b0, mb_} - {1'b0, mls};
        end
        lz = 5'd27;
        for (int k = 0; k < 28; k++) begin
            if (sum[k]) lz = 5'(27 - k);
        end
        // Renormalize so the leading one sits at bit 26, sticky kept in bit 0.
        if (lz == 5'd0) begin
            nsum = {1'b0, sum[27:2], sum[1] | sum[0]};
            er = 11'($signed({3'd0, eb_})) + 11'sd1;
        end else begin
            nsum = sum << (lz - 5'd1);
            er = 11'($signed({3'd0, eb_})) - 11'($signed({6'd0, lz})) + 11'sd1;
        end
        priority if (ca.is_nan || cb.is_nan
                     || (ca.is_inf && cb.is_inf && (i_a[31] != i_b[31]))) begin
            n_s = DefaultNan;
        end else if (ca.is_inf) begin
            n_s = i_a;
        end else if (cb.is_inf) begin
            n_s = i_b;
        end else if (sum == 28'd0) begin
            n_s = {i_a[31] & i_b[31], 31'd0};
        end else begin
            n_s = fp_round_pack(big[31], er, nsum[26:0]);
        end
    end

    // Hold the sum while stalled.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_s <= n_s;
        end
    end

    assign o_s = r_s;

endmodule

// ===== hdl/v4m4_lane.sv =====
// One output lane: four products, then three chained additions.
module v4m4_lane
    import v4m4_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_en,
    input  logic [4*FpW-1:0] i_vec,
    input  logic [4*FpW-1:0] i_col,
    output logic [FpW-1:0]   o_res
);

    logic [FpW-1:0] w_p [4];
    logic [FpW-1:0] w_s0, w_s1;
    logic [FpW-1:0] r_p2a, r_p3a, r_p3b;

    // Products of the vector with this row of the matrix.
    for (genvar g = 0; g < 4; g++) begin : g_mul
        v4m4_fmul u_mul (
            .i_clk (i_clk),
            .i_en  (i_en),
            .i_a   (i_vec[g*FpW +: FpW]),
            .i_b   (i_col[g*FpW +: FpW]),
            .o_p   (w_p[g])
        );
    end

    v4m4_fadd u_add0 (.i_clk(i_clk), .i_en(i_en), .i_a(w_p[0]), .i_b(w_p[1]), .o_s(w_s0));
    v4m4_fadd u_add1 (.i_clk(i_clk), .i_en(i_en), .i_a(w_s0), .i_b(r_p2a), .o_s(w_s1));
    v4m4_fadd u_add2 (.i_clk(i_clk), .i_en(i_en), .i_a(w_s1), .i_b(r_p3b), .o_s(o_res));

    // Delay the later products to meet the running sum.
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_p2a <= w_p[2];
            r_p3a <= w_p[3];
            r_p3b <= r_p3a;
        end
    end

endmodule

// ===== hdl/v4m4_checker.sv =====
// Port-level checker for the transform core, with its bind.
`include "assert_macros.svh"
module v4m4_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        s_axis_tvalid,
    input logic        s_axis_tready,
    input logic        m_axis_tvalid,
    input logic        m_axis_tready,
    input logic [95:0] m_axis_tdata
);
    `ASSERT_NEXT(a_hold, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata), "stalled result changed")
    `ASSERT_IMPLY(a_ready, i_clk, i_rst_n, !m_axis_tvalid, s_axis_tready, "not ready with empty output")
    `ASSERT_IMPLY(a_stall, i_clk, i_rst_n, m_axis_tvalid && !m_axis_tready, !s_axis_tready, "accepted while stalled")
endmodule

bind vec4_mat4_transform_fp32_core v4m4_checker u_chk (.*);
